// ----- rtl/rlpf_pkg.sv -----
// Shared types, constants and register indexes for the roll-to-lamp PWM block.
`timescale 1ns / 1ps

package rlpf_pkg;

    // Width of a lamp level and the cap that it places on max_pwm.
    localparam int          PWM_BITS = 16;
    localparam logic [15:0] LVL_CAP  = 16'((1 << PWM_BITS) - 1);

    // Dividend of the map: whole-degree offset (9 bits) times the level limit (16 bits).
    localparam int NUM_W = 25;
    localparam int CNT_W = $clog2(NUM_W);

    // Depth of the command queue between front and back.
    localparam int Q_DEPTH = 2;
    localparam int QP_W    = $clog2(Q_DEPTH);

    // Configuration register indexes.
    localparam logic [7:0] CFG_MAX_PWM    = 8'd0;
    localparam logic [7:0] CFG_FADE_STEP  = 8'd1;
    localparam logic [7:0] CFG_ANGLE_ON   = 8'd2;
    localparam logic [7:0] CFG_ANGLE_FULL = 8'd3;

    // Which lamp a sample drives.
    localparam logic [1:0] SIDE_NONE  = 2'd0;
    localparam logic [1:0] SIDE_LEFT  = 2'd1;
    localparam logic [1:0] SIDE_RIGHT = 2'd2;

    // How the goal of a sample is formed.
    localparam logic [1:0] GOAL_ZERO = 2'd0;
    localparam logic [1:0] GOAL_LIM  = 2'd1;
    localparam logic [1:0] GOAL_DIV  = 2'd2;

    typedef struct packed {
        logic [1:0]       side;
        logic [1:0]       mode;
        logic [NUM_W-1:0] num;
        logic [7:0]       span;
        logic [15:0]      lim;
    } t_cmd;

endpackage

// ----- rtl/roll_to_lamp_pwm_with_fade.sv -----
// Top level of the roll-angle to lamp PWM mapper with fade.
`timescale 1ns / 1ps

// Channel  Direction  Handshake                  Payload
// input    in         i_in_valid / o_in_stall    i_roll (signed Q8.8 degrees)
// output   out        o_out_valid / i_out_stall  o_left_level, o_right_level,
//                                                o_left_goal, o_right_goal
// config   in         i_cfg_we                   i_cfg_idx, i_cfg_data
//
// A beat enters the two-entry command queue in the cycle it is accepted.
// The back end takes a command in its idle state, runs the serial divider
// when the goal needs the linear map, and then applies the fade; a sample
// whose goal is zero or full scale goes straight from idle to the fade.
// Reset is synchronous and active low; it restores the register defaults and
// puts both lamp levels at zero.
// A stalled result holds in the output register while the queue keeps taking
// beats; the input stalls only once the queue is full.

module roll_to_lamp_pwm_with_fade
    import rlpf_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [7:0]         i_cfg_idx,
    input  logic [15:0]        i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic signed [16:0] i_roll,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [15:0]        o_left_level,
    output logic [15:0]        o_right_level,
    output logic [15:0]        o_left_goal,
    output logic [15:0]        o_right_goal
);

    // Configuration registers. Writes to an index beyond the last register are
    // simply dropped.
    logic [15:0] r_max_pwm;
    logic [15:0] r_fade_step;
    logic [7:0]  r_angle_on;
    logic [7:0]  r_angle_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_pwm    <= 16'd1023;
            r_fade_step  <= 16'd5;
            r_angle_on   <= 8'd10;
            r_angle_full <= 8'd45;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MAX_PWM:    r_max_pwm    <= i_cfg_data;
                CFG_FADE_STEP:  r_fade_step  <= i_cfg_data;
                CFG_ANGLE_ON:   r_angle_on   <= i_cfg_data[7:0];
                CFG_ANGLE_FULL: r_angle_full <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    // The front end classifies each beat and pushes a command; the back end
    // pops commands in order and works each one to a finished result.
    logic q_push;
    logic q_pop;
    logic q_valid;
    logic q_full;
    t_cmd push_cmd;
    t_cmd head_cmd;

    rlpf_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_roll       (i_roll),
        .i_max_pwm    (r_max_pwm),
        .i_angle_on   (r_angle_on),
        .i_angle_full (r_angle_full),
        .i_q_full     (q_full),
        .o_push       (q_push),
        .o_cmd        (push_cmd)
    );

    rlpf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (push_cmd),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_full  (q_full),
        .o_cmd   (head_cmd)
    );

    rlpf_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (q_valid),
        .i_q_cmd       (head_cmd),
        .o_q_pop       (q_pop),
        .i_fade_step   (r_fade_step),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_left_level  (o_left_level),
        .o_right_level (o_right_level),
        .o_left_goal   (o_left_goal),
        .o_right_goal  (o_right_goal)
    );

endmodule

// ----- rtl/rlpf_front.sv -----
// Front end: takes roll beats, classifies them and forms the division command.
`timescale 1ns / 1ps

module rlpf_front
    import rlpf_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic signed [16:0] i_roll,
    input  logic [15:0]        i_max_pwm,
    input  logic [7:0]         i_angle_on,
    input  logic [7:0]         i_angle_full,
    input  logic               i_q_full,
    output logic               o_push,
    output t_cmd               o_cmd
);

    logic signed [17:0] roll_x;
    logic signed [17:0] thr;
    logic               go_right;
    logic               go_left;
    logic signed [17:0] neg_roll;
    logic [16:0]        mag;
    logic [8:0]         dnum;
    logic [15:0]        lim;
    logic signed [8:0]  span;

    assign roll_x   = {i_roll[16], i_roll};
    assign thr      = {2'b00, i_angle_on, 8'h00};
    assign go_right = roll_x > thr;
    assign go_left  = roll_x < -thr;
    assign neg_roll = -roll_x;
    assign mag      = go_left ? neg_roll[16:0] : roll_x[16:0];
    // An active sample always has a whole-degree part at or above the threshold.
    assign dnum     = mag[16:8] - {1'b0, i_angle_on};
    assign lim      = (i_max_pwm < LVL_CAP) ? i_max_pwm : LVL_CAP;
    assign span     = $signed({1'b0, i_angle_full}) - $signed({1'b0, i_angle_on});

    assign o_in_stall = i_q_full;
    assign o_push     = i_in_valid && !i_q_full;

    always_comb begin
        o_cmd.side = go_right ? SIDE_RIGHT : (go_left ? SIDE_LEFT : SIDE_NONE);
        o_cmd.num  = NUM_W'(dnum) * NUM_W'(lim);
        o_cmd.span = span[7:0];
        o_cmd.lim  = lim;
        priority if (!(go_right || go_left)) begin
            o_cmd.mode = GOAL_ZERO;
        end else if (span == 9'sd0) begin
            o_cmd.mode = GOAL_LIM;
        end else if (span[8]) begin
            // Reversed angles give a quotient of zero or below, which clamps to zero.
            o_cmd.mode = GOAL_ZERO;
        end else begin
            o_cmd.mode = GOAL_DIV;
        end
    end

`ifndef SYNTHESIS
    a_stall_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_q_full |-> !o_push)
        else $error("push into a full queue");
    a_one_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(go_right && go_left))
        else $error("sample classified as both left and right");
    a_div_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && o_cmd.mode == GOAL_DIV) |-> (o_cmd.span != 8'd0))
        else $error("division command with zero span");
`endif

endmodule

// ----- rtl/rlpf_queue.sv -----
// Short command queue that decouples the front end from the back end.
`timescale 1ns / 1ps

module rlpf_queue
    import rlpf_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output logic o_valid,
    output logic o_full,
    output t_cmd o_cmd
);

    t_cmd            r_mem [Q_DEPTH];
    logic [QP_W-1:0] r_wr_ptr;
    logic [QP_W-1:0] r_rd_ptr;
    logic [QP_W:0]   r_count;
    logic            do_pop;

    assign o_valid = (r_count != '0);
    assign o_full  = (r_count == (QP_W + 1)'(Q_DEPTH));
    assign o_cmd   = r_mem[r_rd_ptr];
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == QP_W'(Q_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == QP_W'(Q_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            r_count <= r_count + (QP_W + 1)'(i_push) - (QP_W + 1)'(do_pop);
        end
    end

endmodule

// ----- rtl/rlpf_back.sv -----
// Back end: serial divider for the goal, fade of both lamp levels, output register.
`timescale 1ns / 1ps

module rlpf_back
    import rlpf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_q_valid,
    input  t_cmd        i_q_cmd,
    output logic        o_q_pop,
    input  logic [15:0] i_fade_step,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [15:0] o_left_level,
    output logic [15:0] o_right_level,
    output logic [15:0] o_left_goal,
    output logic [15:0] o_right_goal
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_FADE = 2'd2;

    logic [1:0]       r_state,    n_state;
    logic [1:0]       r_side,     n_side;
    logic [7:0]       r_span,     n_span;
    logic [15:0]      r_lim,      n_lim;
    logic [15:0]      r_goal,     n_goal;
    logic             r_use_quo,  n_use_quo;
    logic [NUM_W-1:0] r_quo,      n_quo;
    logic [7:0]       r_rem,      n_rem;
    logic [CNT_W-1:0] r_cnt,      n_cnt;
    logic [15:0]      r_ldut,     n_ldut;
    logic [15:0]      r_rdut,     n_rdut;
    logic             r_out_valid, n_out_valid;
    logic [15:0]      r_lgoal,    n_lgoal;
    logic [15:0]      r_rgoal,    n_rgoal;

    logic [8:0]  rem_sh;
    logic        rem_ge;
    logic [15:0] goal;
    logic [15:0] lgoal;
    logic [15:0] rgoal;
    logic        slot_free;

    function automatic logic [15:0] fade(input logic [15:0] cur, input logic [15:0] tgt,
                                         input logic [15:0] step);
        logic [16:0] sum;
        logic [15:0] gap;
        sum = {1'b0, cur} + {1'b0, step};
        gap = cur - tgt;
        if (cur < tgt) begin
            fade = (sum > {1'b0, tgt}) ? tgt : sum[15:0];
        end else if (cur > tgt) begin
            fade = (gap <= step) ? tgt : cur - step;
        end else begin
            fade = cur;
        end
    endfunction

    assign rem_sh    = {r_rem, r_quo[NUM_W-1]};
    assign rem_ge    = rem_sh >= {1'b0, r_span};
    assign slot_free = !r_out_valid || !i_out_stall;
    assign o_q_pop   = (r_state == ST_IDLE) && i_q_valid;

    always_comb begin
        if (r_use_quo) begin
            goal = (r_quo > NUM_W'(r_lim)) ? r_lim : r_quo[15:0];
        end else begin
            goal = r_goal;
        end
        lgoal = (r_side == SIDE_LEFT)  ? goal : 16'd0;
        rgoal = (r_side == SIDE_RIGHT) ? goal : 16'd0;
    end

    always_comb begin
        n_state     = r_state;
        n_side      = r_side;
        n_span      = r_span;
        n_lim       = r_lim;
        n_goal      = r_goal;
        n_use_quo   = r_use_quo;
        n_quo       = r_quo;
        n_rem       = r_rem;
        n_cnt       = r_cnt;
        n_ldut      = r_ldut;
        n_rdut      = r_rdut;
        n_lgoal     = r_lgoal;
        n_rgoal     = r_rgoal;
        n_out_valid = r_out_valid && i_out_stall;
        unique case (r_state)
            ST_IDLE: begin
                if (i_q_valid) begin
                    n_side    = i_q_cmd.side;
                    n_span    = i_q_cmd.span;
                    n_lim     = i_q_cmd.lim;
                    n_quo     = i_q_cmd.num;
                    n_rem     = 8'd0;
                    n_cnt     = '0;
                    n_use_quo = (i_q_cmd.mode == GOAL_DIV);
                    n_goal    = (i_q_cmd.mode == GOAL_LIM) ? i_q_cmd.lim : 16'd0;
                    n_state   = (i_q_cmd.mode == GOAL_DIV) ? ST_DIV : ST_FADE;
                end
            end
            ST_DIV: begin
                n_rem = rem_ge ? 8'(rem_sh - {1'b0, r_span}) : rem_sh[7:0];
                n_quo = {r_quo[NUM_W-2:0], rem_ge};
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(NUM_W - 1)) begin
                    n_state = ST_FADE;
                end
            end
            ST_FADE: begin
                if (slot_free) begin
                    n_ldut      = fade(r_ldut, lgoal, i_fade_step);
                    n_rdut      = fade(r_rdut, rgoal, i_fade_step);
                    n_lgoal     = lgoal;
                    n_rgoal     = rgoal;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_ldut      <= 16'd0;
            r_rdut      <= 16'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ldut      <= n_ldut;
            r_rdut      <= n_rdut;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_side    <= n_side;
        r_span    <= n_span;
        r_lim     <= n_lim;
        r_goal    <= n_goal;
        r_use_quo <= n_use_quo;
        r_quo     <= n_quo;
        r_rem     <= n_rem;
        r_cnt     <= n_cnt;
        r_lgoal   <= n_lgoal;
        r_rgoal   <= n_rgoal;
    end

    assign o_out_valid   = r_out_valid;
    assign o_left_level  = r_ldut;
    assign o_right_level = r_rdut;
    assign o_left_goal   = r_lgoal;
    assign o_right_goal  = r_rgoal;

`ifndef SYNTHESIS
    a_rem_below_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> (r_span != 8'd0 && r_rem < r_span))
        else $error("divider remainder out of range");
    a_one_lamp_goal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_lgoal == 16'd0 || r_rgoal == 16'd0))
        else $error("both lamps given a goal");
    a_no_overshoot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FADE && slot_free) |=>
        ((r_ldut >= $past(r_ldut) && r_ldut <= $past(lgoal)) ||
         (r_ldut <= $past(r_ldut) && r_ldut >= $past(lgoal))))
        else $error("left level passed its goal");
`endif

endmodule

// ----- sim/testbench.sv -----
// Self-checking testbench for the roll-to-lamp PWM mapper with fade.
`timescale 1ns / 1ps

module testbench;
    import rlpf_pkg::*;

    // A register index that the block does not decode; writes to it must be ignored.
    localparam logic [7:0] CFG_UNUSED_IDX = 8'd7;

    localparam int CLK_HALF     = 5;
    localparam int NUM_PHASES   = 8;
    localparam int PHASE_ITEMS  = 205;
    localparam int HOLD_CYCLES  = 300;
    localparam int SETTLE       = 4;
    localparam int TAIL_CYCLES  = 60;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [15:0] left_level;
        logic [15:0] right_level;
        logic [15:0] left_goal;
        logic [15:0] right_goal;
    } t_lamp_result;

    // Tracks the registers and both lamp levels, and holds the results still owed.
    class t_lamp_scoreboard;
        logic [15:0]  max_pwm;
        logic [15:0]  fade_step;
        logic [7:0]   angle_on;
        logic [7:0]   angle_full;
        logic [15:0]  left_duty;
        logic [15:0]  right_duty;
        t_lamp_result awaited_lamps[$];
        int           mismatches;
        int           samples_seen;
        int           results_seen;

        function new();
            max_pwm      = 16'd1023;
            fade_step    = 16'd5;
            angle_on     = 8'd10;
            angle_full   = 8'd45;
            left_duty    = '0;
            right_duty   = '0;
            mismatches   = 0;
            samples_seen = 0;
            results_seen = 0;
        endfunction

        function void write_reg(logic [7:0] idx, logic [15:0] data);
            case (idx)
                CFG_MAX_PWM:    max_pwm    = data;
                CFG_FADE_STEP:  fade_step  = data;
                CFG_ANGLE_ON:   angle_on   = data[7:0];
                CFG_ANGLE_FULL: angle_full = data[7:0];
                default: ;
            endcase
        endfunction

        // Target level for a magnitude (Q8.8) that already lies past the threshold.
        function logic [15:0] lamp_goal(int mag);
            longint lim;
            longint deg;
            longint span;
            longint v;
            lim  = (max_pwm < LVL_CAP) ? longint'(max_pwm) : longint'(LVL_CAP);
            deg  = mag / 256;
            span = longint'(angle_full) - longint'(angle_on);
            if (span == 0) begin
                return lim[15:0];
            end
            v = ((deg - longint'(angle_on)) * lim) / span;
            if (v < 0) v = 0;
            if (v > lim) v = lim;
            return v[15:0];
        endfunction

        function logic [15:0] faded(logic [15:0] cur, logic [15:0] goal);
            longint c;
            longint g;
            longint s;
            c = longint'(cur);
            g = longint'(goal);
            s = longint'(fade_step);
            if (c < g) begin
                c = c + s;
                if (c > g) c = g;
            end else if (c > g) begin
                c = c - s;
                if (c < g) c = g;
            end
            return c[15:0];
        endfunction

        function void note_sample(logic signed [16:0] roll);
            int           r;
            int           thr;
            t_lamp_result e;
            r = roll;
            thr = int'(angle_on) * 256;
            e.left_goal  = '0;
            e.right_goal = '0;
            if (r > thr) e.right_goal = lamp_goal(r);
            if (r < -thr) e.left_goal = lamp_goal(-r);
            left_duty  = faded(left_duty, e.left_goal);
            right_duty = faded(right_duty, e.right_goal);
            e.left_level  = left_duty;
            e.right_level = right_duty;
            awaited_lamps.push_back(e);
            samples_seen++;
        endfunction

        function void check_result(t_lamp_result got);
            t_lamp_result e;
            results_seen++;
            if (awaited_lamps.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("[%0t] unexpected result: L %0d R %0d goals %0d/%0d", $realtime,
                             got.left_level, got.right_level, got.left_goal, got.right_goal);
                return;
            end
            e = awaited_lamps.pop_front();
            if (got !== e) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("[%0t] mismatch: expected L %0d R %0d goals %0d/%0d, got L %0d R %0d goals %0d/%0d",
                             $realtime, e.left_level, e.right_level, e.left_goal, e.right_goal,
                             got.left_level, got.right_level, got.left_goal, got.right_goal);
            end
        endfunction

        function int pending();
            return awaited_lamps.size();
        endfunction
    endclass

    logic               i_clk         = 1'b0;
    logic               i_rst_n       = 1'b0;
    logic               i_cfg_we      = 1'b0;
    logic [7:0]         i_cfg_idx     = '0;
    logic [15:0]        i_cfg_data    = '0;
    logic               i_in_valid    = 1'b0;
    logic               o_in_stall;
    logic signed [16:0] i_roll        = '0;
    logic               o_out_valid;
    logic               i_out_stall   = 1'b0;
    logic [15:0]        o_left_level;
    logic [15:0]        o_right_level;
    logic [15:0]        o_left_goal;
    logic [15:0]        o_right_goal;

    t_lamp_scoreboard lamps;
    bit             steady        = 1'b0;
    int             hold_request  = 0;
    int             hold_left     = 0;
    int             cycle_count   = 0;
    int             settings_used = 0;

    roll_to_lamp_pwm_with_fade uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_roll        (i_roll),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_left_level  (o_left_level),
        .o_right_level (o_right_level),
        .o_left_goal   (o_left_goal),
        .o_right_goal  (o_right_goal)
    );

    initial begin
        forever begin
            #CLK_HALF i_clk = ~i_clk;
        end
    end

    // Guard against a hung handshake: the run cannot legitimately take this long.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles with %0d results outstanding.",
                     cycle_count, lamps.pending());
            $display("Test completed with failures");
            $finish;
        end
    end

    // Result side. Each accepted beat is checked against the oldest prediction; the stall
    // is then chosen for the next edge. A requested hold-off is counted down here, in
    // cycles, independently of whatever the sender is doing.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid === 1'b1 && !i_out_stall)
            lamps.check_result({o_left_level, o_right_level, o_left_goal, o_right_goal});
        if (hold_request != 0) begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= !steady && ($urandom_range(99) < 34);
        end
    end

    // Offers one roll beat, possibly after a few idle cycles, and holds it until taken.
    task automatic send_sample(input logic signed [16:0] roll);
        while (!steady && $urandom_range(99) < 34) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_roll     <= roll;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        lamps.note_sample(roll);
    endtask

    // Withdraws the input and waits until every predicted result has been returned.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (lamps.pending() != 0) @(posedge i_clk);
    endtask

    // Writes all four registers while the block is idle; optionally also pokes an
    // index that must be ignored.
    task automatic apply_settings(input logic [15:0] lim, input logic [15:0] step,
                                  input logic [15:0] a_on, input logic [15:0] a_full,
                                  input bit poke_unused);
        logic [7:0]  idx_list[5];
        logic [15:0] val_list[5];
        int          n;
        idx_list = '{CFG_MAX_PWM, CFG_FADE_STEP, CFG_ANGLE_ON, CFG_ANGLE_FULL, CFG_UNUSED_IDX};
        val_list = '{lim, step, a_on, a_full, 16'($urandom())};
        n = poke_unused ? 5 : 4;
        wait_drained();
        repeat (SETTLE) @(posedge i_clk);
        for (int k = 0; k < n; k++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= idx_list[k];
            i_cfg_data <= val_list[k];
            @(posedge i_clk);
            lamps.write_reg(idx_list[k], val_list[k]);
        end
        i_cfg_we <= 1'b0;
        settings_used++;
    endtask

    // Random roll with a bias towards sustained leans and the interesting angles.
    function automatic logic signed [16:0] next_roll(logic signed [16:0] prev);
        int sel;
        int base;
        int v;
        sel = $urandom_range(99);
        if (sel < 30) begin
            v = prev;
        end else if (sel < 50) begin
            v = int'($urandom_range(92160)) - 46080;
        end else if (sel < 70) begin
            base = int'(lamps.angle_on) * 256 + int'($urandom_range(600)) - 300;
            v = $urandom_range(1) ? base : -base;
        end else if (sel < 80) begin
            base = int'(lamps.angle_full) * 256 + int'($urandom_range(600)) - 300;
            v = $urandom_range(1) ? base : -base;
        end else if (sel < 90) begin
            v = $urandom();
        end else begin
            case ($urandom_range(4))
                0: v = 46080;
                1: v = -46080;
                2: v = 65535;
                3: v = -65536;
                default: v = 0;
            endcase
        end
        return 17'(v);
    endfunction

    initial begin
        logic signed [16:0] roll;
        int                 a;
        lamps = new();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed beats at the reset settings: exact threshold, a fraction past it,
        // full scale, the field limits and a few plain angles.
        send_sample(17'sd0);
        send_sample(17'sd2560);
        send_sample(17'sd2561);
        send_sample(-17'sd2561);
        send_sample(17'sd2816);
        send_sample(17'sd11520);
        send_sample(-17'sd11520);
        send_sample(17'sd46080);
        send_sample(-17'sd46080);
        send_sample(17'sd65535);
        send_sample(-17'sd65536);

        // Equal angles give full scale once past the threshold.
        apply_settings(16'd500, 16'd1000, 16'd20, 16'd20, 1'b0);
        send_sample(17'sd5121);
        send_sample(-17'sd5121);
        send_sample(17'sd5120);

        // Reversed angles clamp to zero.
        apply_settings(16'd800, 16'd100, 16'd50, 16'd30, 1'b0);
        send_sample(17'sd20000);
        send_sample(-17'sd20000);

        // A zero fade step freezes both levels.
        apply_settings(16'd800, 16'd0, 16'd5, 16'd60, 1'b0);
        send_sample(17'sd30000);
        send_sample(-17'sd30000);

        // Widest settings, plus a write to an index that must change nothing.
        apply_settings(16'hFFFF, 16'hFFFF, 16'd0, 16'd180, 1'b1);
        send_sample(17'sd46080);
        send_sample(17'sd1);
        send_sample(-17'sd1);
        send_sample(-17'sd65536);

        // Narrowest settings.
        apply_settings(16'd1, 16'd1, 16'd179, 16'd180, 1'b0);
        send_sample(17'sd46080);

        // Random phases, each under its own register settings.
        roll = '0;
        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p)
                0: apply_settings(16'd1023, 16'd5, 16'd10, 16'd45, 1'b0);
                1: apply_settings(16'hFFFF, 16'($urandom_range(1, 4000)), 16'd0, 16'd180, 1'b0);
                2: begin
                    a = $urandom_range(0, 178);
                    apply_settings(16'($urandom_range(1, 3)), 16'd1, 16'(a), 16'(a + 1), 1'b0);
                end
                3: begin
                    a = $urandom_range(0, 179);
                    apply_settings(16'($urandom_range(1, 65535)), 16'($urandom_range(1, 300)),
                                   16'(a), 16'(a), 1'b0);
                end
                4: apply_settings(16'($urandom()), 16'($urandom()), 16'($urandom()),
                                  16'($urandom()), 1'b1);
                default: begin
                    a = $urandom_range(0, 60);
                    apply_settings(16'($urandom_range(1, 65535)), 16'($urandom_range(1, 2000)),
                                   16'(a), 16'($urandom_range(a + 1, 180)), 1'b0);
                end
            endcase
            // One phase runs with no idling on either side.
            steady = (p == 5);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // Hold results back for a long stretch while beats keep coming, so the
                // queue fills and the input stalls.
                if (p == 6 && n == 40) hold_request = HOLD_CYCLES;
                // Stop sending until everything owed has come back, then carry on.
                if (p == 7 && n == PHASE_ITEMS / 2) wait_drained();
                roll = next_roll(roll);
                send_sample(roll);
            end
            steady = 1'b0;
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (lamps.pending() != 0) lamps.mismatches += lamps.pending();

        $display("Sent %0d roll samples under %0d register settings; %0d results compared.",
                 lamps.samples_seen, settings_used, lamps.results_seen);
        $display("Mismatches: %0d, cycles used: %0d.", lamps.mismatches, cycle_count);
        if (lamps.mismatches == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ----- files.f -----
rtl/rlpf_pkg.sv
rtl/rlpf_front.sv
rtl/rlpf_queue.sv
rtl/rlpf_back.sv
rtl/roll_to_lamp_pwm_with_fade.sv
sim/testbench.sv
